[rtl/mpq_pkg.sv]
`default_nettype none

package mpq_pkg;

  localparam int MAX_ENTRIES_DEF = 16;
  localparam int KEY_BITS_DEF = 16;

  localparam int CMD_W = 2;
  localparam int IN_KEY_W = 16;
  localparam int HANDLE_W = 4;
  localparam int STATUS_W = 2;
  localparam int COUNT_W = 5;

  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DEL_MAX = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CHANGE = 2'd2;
  localparam logic [CMD_W-1:0] CMD_DELETE = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;
  localparam logic [STATUS_W-1:0] ST_BAD_HANDLE = 2'd3;

  typedef struct packed {
    logic [CMD_W-1:0]    command;
    logic [IN_KEY_W-1:0] key;
    logic [HANDLE_W-1:0] handle;
  } in_req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [IN_KEY_W-1:0] out_key;
    logic [HANDLE_W-1:0] out_handle;
    logic                is_empty;
    logic [COUNT_W-1:0]  entry_count;
  } out_res_t;

  typedef struct packed {
    logic better;
    logic above;
  } scan_res_t;

endpackage

`default_nettype wire

[rtl/mpq_ram.sv]
`default_nettype none

module mpq_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

[rtl/mpq_scan_unit.sv]
`default_nettype none

module mpq_scan_unit #(
  parameter int KEY_BITS = 16,
  parameter int RANK_W = 4
) (
  input  wire logic                found,
  input  wire logic [KEY_BITS-1:0] slot_key,
  input  wire logic [RANK_W-1:0]   slot_rank,
  input  wire logic [KEY_BITS-1:0] best_key,
  input  wire logic [RANK_W-1:0]   best_rank,
  output mpq_pkg::scan_res_t       res,
  output logic      [RANK_W-1:0]   rank_inc,
  output logic      [RANK_W-1:0]   rank_dec
);

  import mpq_pkg::*;

  // A newer entry carries a smaller rank and wins a tie on the key.
  always_comb begin
    res.better = !found || (slot_key > best_key) ||
                 ((slot_key == best_key) && (slot_rank < best_rank));
    res.above = slot_rank > best_rank;
  end

  assign rank_inc = slot_rank + RANK_W'(1);
  assign rank_dec = slot_rank - RANK_W'(1);

endmodule

`default_nettype wire

[rtl/max_priority_queue_with_handles_core.sv]
`default_nettype none

// Bounded max priority queue with handles, one request at a time. Each slot's key and
// recency rank sit in one entry memory that is swept one slot per clock. An insert sweeps
// the memory once, a delete maximum sweeps it twice, a delete by handle reads its entry
// and then sweeps once, a key change reads and rewrites one entry, and a refused request
// goes straight to its result. The input stalls while a request is in work, and a new
// request is taken while the previous result still waits on the output.

module max_priority_queue_with_handles_core #(
  parameter int MAX_ENTRIES = mpq_pkg::MAX_ENTRIES_DEF,
  parameter int KEY_BITS = mpq_pkg::KEY_BITS_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire mpq_pkg::in_req_t in_data,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output mpq_pkg::out_res_t     out_data
);

  import mpq_pkg::*;

  localparam int AW = $clog2(MAX_ENTRIES);
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int RW = KEY_BITS + AW;
  localparam logic [AW-1:0] LAST = AW'(MAX_ENTRIES - 1);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_SWEEP = 6'b000010,
    S_RDH   = 6'b000100,
    S_RDW   = 6'b001000,
    S_INS   = 6'b010000,
    S_FIN   = 6'b100000
  } state_t;

  state_t                state_r;
  logic [CMD_W-1:0]      cmd_r;
  logic [KEY_BITS-1:0]   key_r;
  logic [AW-1:0]         hdl_r;
  logic [MAX_ENTRIES-1:0] valid_r;
  logic [CW-1:0]         count_r;
  logic [AW-1:0]         idx_r;
  logic                  iss_r;
  logic                  pv_r;
  logic [AW-1:0]         pidx_r;
  logic                  dec_r;
  logic                  found_r;
  logic [AW-1:0]         best_r;
  logic [KEY_BITS-1:0]   bkey_r;
  logic [AW-1:0]         brank_r;
  logic [STATUS_W-1:0]   status_r;
  logic [KEY_BITS-1:0]   okey_r;
  logic [AW-1:0]         ohdl_r;
  logic                  out_valid_r;
  out_res_t              out_r;

  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [RW-1:0]         ram_wdata;
  logic [AW-1:0]         ram_raddr;
  logic [RW-1:0]         ram_rdata;
  logic [KEY_BITS-1:0]   rd_key;
  logic [AW-1:0]         rd_rank;
  scan_res_t             sres;
  logic [AW-1:0]         rank_inc;
  logic [AW-1:0]         rank_dec;

  logic                  in_acc;
  logic                  out_free;
  logic                  h_ok;
  logic [AW-1:0]         in_hidx;
  logic                  p_valid;
  logic                  p_last;
  logic [63:0]           okey_w;
  logic [31:0]           ohdl_w;
  logic [31:0]           cnt_w;

  mpq_ram #(
    .WIDTH(RW),
    .DEPTH(MAX_ENTRIES)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign rd_key = ram_rdata[RW-1:AW];
  assign rd_rank = ram_rdata[AW-1:0];

  mpq_scan_unit #(
    .KEY_BITS(KEY_BITS),
    .RANK_W  (AW)
  ) u_scan (
    .found    (found_r),
    .slot_key (rd_key),
    .slot_rank(rd_rank),
    .best_key (bkey_r),
    .best_rank(brank_r),
    .res      (sres),
    .rank_inc (rank_inc),
    .rank_dec (rank_dec)
  );

  assign in_stall = (state_r != S_IDLE);
  assign in_acc = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign in_hidx = AW'(in_data.handle);
  assign h_ok = (32'(in_data.handle) < 32'(MAX_ENTRIES)) && valid_r[in_hidx];
  assign p_valid = valid_r[pidx_r];
  assign p_last = pv_r && (pidx_r == LAST);

  assign okey_w = 64'(okey_r);
  assign ohdl_w = 32'(ohdl_r);
  assign cnt_w = 32'(count_r);

  always_comb begin
    ram_raddr = (state_r == S_RDH) ? hdl_r : idx_r;
    ram_we = 1'b0;
    ram_waddr = pidx_r;
    ram_wdata = {rd_key, rd_rank};
    case (state_r)
      S_SWEEP: begin
        if (pv_r && p_valid) begin
          if (cmd_r == CMD_INSERT) begin
            ram_we = 1'b1;
            ram_wdata = {rd_key, rank_inc};
          end else if (dec_r && sres.above) begin
            ram_we = 1'b1;
            ram_wdata = {rd_key, rank_dec};
          end
        end
      end
      S_RDW: begin
        if (cmd_r == CMD_CHANGE) begin
          ram_we = 1'b1;
          ram_waddr = hdl_r;
          ram_wdata = {key_r, rd_rank};
        end
      end
      S_INS: begin
        ram_we = 1'b1;
        ram_waddr = best_r;
        ram_wdata = {key_r, AW'(0)};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      valid_r <= '0;
      count_r <= '0;
      iss_r <= 1'b0;
      pv_r <= 1'b0;
      dec_r <= 1'b0;
      found_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall && (state_r != S_FIN)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            cmd_r <= in_data.command;
            key_r <= KEY_BITS'(in_data.key);
            hdl_r <= in_hidx;
            status_r <= ST_OK;
            okey_r <= '0;
            ohdl_r <= '0;
            dec_r <= 1'b0;
            found_r <= 1'b0;
            idx_r <= '0;
            pv_r <= 1'b0;
            case (in_data.command)
              CMD_INSERT: begin
                if (count_r == CW'(MAX_ENTRIES)) begin
                  status_r <= ST_FULL;
                  state_r <= S_FIN;
                end else begin
                  iss_r <= 1'b1;
                  state_r <= S_SWEEP;
                end
              end
              CMD_DEL_MAX: begin
                if (count_r == '0) begin
                  status_r <= ST_EMPTY;
                  state_r <= S_FIN;
                end else begin
                  iss_r <= 1'b1;
                  state_r <= S_SWEEP;
                end
              end
              default: begin
                if (!h_ok) begin
                  status_r <= ST_BAD_HANDLE;
                  state_r <= S_FIN;
                end else begin
                  state_r <= S_RDH;
                end
              end
            endcase
          end
        end
        S_SWEEP: begin
          if (iss_r) begin
            if (idx_r == LAST) begin
              iss_r <= 1'b0;
            end else begin
              idx_r <= idx_r + AW'(1);
            end
          end
          pv_r <= iss_r;
          pidx_r <= idx_r;
          if (pv_r) begin
            if (cmd_r == CMD_INSERT) begin
              if (!p_valid && !found_r) begin
                found_r <= 1'b1;
                best_r <= pidx_r;
              end
            end else if (!dec_r) begin
              if (p_valid && sres.better) begin
                found_r <= 1'b1;
                best_r <= pidx_r;
                bkey_r <= rd_key;
                brank_r <= rd_rank;
              end
            end
          end
          if (p_last) begin
            if (cmd_r == CMD_INSERT) begin
              state_r <= S_INS;
            end else if (!dec_r) begin
              dec_r <= 1'b1;
              idx_r <= '0;
              iss_r <= 1'b1;
            end else begin
              valid_r[best_r] <= 1'b0;
              count_r <= count_r - CW'(1);
              if (cmd_r == CMD_DEL_MAX) begin
                okey_r <= bkey_r;
                ohdl_r <= best_r;
              end
              state_r <= S_FIN;
            end
          end
        end
        S_RDH: begin
          state_r <= S_RDW;
        end
        S_RDW: begin
          if (cmd_r == CMD_CHANGE) begin
            state_r <= S_FIN;
          end else begin
            best_r <= hdl_r;
            brank_r <= rd_rank;
            dec_r <= 1'b1;
            idx_r <= '0;
            iss_r <= 1'b1;
            pv_r <= 1'b0;
            state_r <= S_SWEEP;
          end
        end
        S_INS: begin
          valid_r[best_r] <= 1'b1;
          count_r <= count_r + CW'(1);
          ohdl_r <= best_r;
          state_r <= S_FIN;
        end
        S_FIN: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_r.status <= status_r;
            out_r.out_key <= okey_w[IN_KEY_W-1:0];
            out_r.out_handle <= ohdl_w[HANDLE_W-1:0];
            out_r.is_empty <= (count_r == '0);
            out_r.entry_count <= cnt_w[COUNT_W-1:0];
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data = out_r;

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_ENTRIES))
    else $error("entry count exceeds capacity");

  a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> ($countones(valid_r) == 32'(count_r)))
    else $error("entry count disagrees with valid slots");

  a_out_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_FIN))
    else $error("result raised outside the finish step");

  a_no_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE || state_r == S_FIN) |-> !ram_we)
    else $error("entry memory written while no request is in work");

endmodule

`default_nettype wire

[verif/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
  import mpq_pkg::*;

  localparam int NSLOTS = MAX_ENTRIES_DEF;
  localparam int RANDOM_ITEMS = 1600;
  localparam int LIMIT_CYCLES = 400000;
  localparam int DRAIN_CYCLES = 2 * NSLOTS + 40;
  localparam int DIR_ROWS_N = 26;

  typedef struct packed {
    in_req_t  req;
    logic     typed;
    out_res_t res;
  } dir_row_t;

  localparam out_res_t NO_RES = '0;

  localparam dir_row_t DIR_ROWS [DIR_ROWS_N] = '{
    '{'{CMD_DEL_MAX, 16'h0000, 4'd0},  1'b1, '{ST_EMPTY, 16'h0000, 4'd0, 1'b1, 5'd0}},
    '{'{CMD_CHANGE, 16'h1234, 4'd0},   1'b1, '{ST_BAD_HANDLE, 16'h0000, 4'd0, 1'b1, 5'd0}},
    '{'{CMD_DELETE, 16'h0000, 4'd15},  1'b1, '{ST_BAD_HANDLE, 16'h0000, 4'd0, 1'b1, 5'd0}},
    '{'{CMD_INSERT, 16'h0000, 4'd15},  1'b1, '{ST_OK, 16'h0000, 4'd0, 1'b0, 5'd1}},
    '{'{CMD_INSERT, 16'hFFFF, 4'd0},   1'b1, '{ST_OK, 16'h0000, 4'd1, 1'b0, 5'd2}},
    '{'{CMD_INSERT, 16'hFFFF, 4'd0},   1'b1, '{ST_OK, 16'h0000, 4'd2, 1'b0, 5'd3}},
    '{'{CMD_DEL_MAX, 16'h0000, 4'd0},  1'b1, '{ST_OK, 16'hFFFF, 4'd2, 1'b0, 5'd2}},
    '{'{CMD_CHANGE, 16'hFFFF, 4'd0},   1'b0, NO_RES},
    '{'{CMD_DEL_MAX, 16'h0000, 4'd0},  1'b0, NO_RES},
    '{'{CMD_DELETE, 16'h0000, 4'd1},   1'b1, '{ST_BAD_HANDLE, 16'h0000, 4'd0, 1'b0, 5'd1}},
    '{'{CMD_INSERT, 16'h8000, 4'd0},   1'b0, NO_RES},
    '{'{CMD_INSERT, 16'h0001, 4'd5},   1'b0, NO_RES},
    '{'{CMD_INSERT, 16'h7FFF, 4'd10},  1'b0, NO_RES},
    '{'{CMD_INSERT, 16'h8000, 4'd0},   1'b0, NO_RES},
    '{'{CMD_INSERT, 16'hAAAA, 4'd0},   1'b0, NO_RES},
    '{'{CMD_INSERT, 16'h5555, 4'd0},   1'b0, NO_RES},
    '{'{CMD_INSERT, 16'h00FF, 4'd0},   1'b0, NO_RES},
    '{'{CMD_INSERT, 16'hFF00, 4'd0},   1'b0, NO_RES},
    '{'{CMD_INSERT, 16'h0F0F, 4'd0},   1'b0, NO_RES},
    '{'{CMD_INSERT, 16'hF0F0, 4'd0},   1'b0, NO_RES},
    '{'{CMD_INSERT, 16'h3333, 4'd0},   1'b0, NO_RES},
    '{'{CMD_INSERT, 16'hCCCC, 4'd0},   1'b0, NO_RES},
    '{'{CMD_INSERT, 16'hFFFE, 4'd0},   1'b0, NO_RES},
    '{'{CMD_INSERT, 16'h0002, 4'd0},   1'b0, NO_RES},
    '{'{CMD_INSERT, 16'h1234, 4'd0},   1'b0, NO_RES},
    '{'{CMD_INSERT, 16'h4321, 4'd0},   1'b1, '{ST_FULL, 16'h0000, 4'd0, 1'b0, 5'd16}}
  };

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  in_req_t  in_data;
  logic     out_valid;
  logic     out_stall;
  out_res_t out_data;

  logic        pq_valid [NSLOTS];
  logic [15:0] pq_key [NSLOTS];
  int          pq_rank [NSLOTS];
  int          pq_count;

  out_res_t expected_q [$];
  out_res_t want;
  int       errors;
  int       results_checked;
  int       requests_sent;
  int       status_hits [4];
  int       cycles;
  int       tx_idle_pct;
  int       rx_idle_pct;

  max_priority_queue_with_handles_core dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic void pq_drop(input int s);
    int i;
    for (i = 0; i < NSLOTS; i++) begin
      if (pq_valid[i] && pq_rank[i] > pq_rank[s]) begin
        pq_rank[i]--;
      end
    end
    pq_valid[s] = 1'b0;
    pq_count--;
  endfunction

  function automatic out_res_t pq_predict(input in_req_t r);
    out_res_t res;
    int i;
    int slot;
    int best;
    res = '0;
    res.status = ST_OK;
    case (r.command)
      CMD_INSERT: begin
        if (pq_count >= NSLOTS) begin
          res.status = ST_FULL;
        end else begin
          slot = 0;
          while (pq_valid[slot]) slot++;
          for (i = 0; i < NSLOTS; i++) begin
            if (pq_valid[i]) pq_rank[i]++;
          end
          pq_valid[slot] = 1'b1;
          pq_key[slot] = r.key;
          pq_rank[slot] = 0;
          pq_count++;
          res.out_handle = slot[HANDLE_W-1:0];
        end
      end
      CMD_DEL_MAX: begin
        if (pq_count == 0) begin
          res.status = ST_EMPTY;
        end else begin
          best = -1;
          for (i = 0; i < NSLOTS; i++) begin
            if (pq_valid[i] && (best < 0 || pq_key[i] > pq_key[best] ||
                (pq_key[i] == pq_key[best] && pq_rank[i] < pq_rank[best]))) begin
              best = i;
            end
          end
          res.out_key = pq_key[best];
          res.out_handle = best[HANDLE_W-1:0];
          pq_drop(best);
        end
      end
      default: begin
        if (!pq_valid[r.handle]) begin
          res.status = ST_BAD_HANDLE;
        end else if (r.command == CMD_CHANGE) begin
          pq_key[r.handle] = r.key;
        end else begin
          pq_drop(int'(r.handle));
        end
      end
    endcase
    res.is_empty = (pq_count == 0);
    res.entry_count = pq_count[COUNT_W-1:0];
    return res;
  endfunction

  function automatic in_req_t random_request(input int insert_pct);
    in_req_t r;
    int start;
    int k;
    case ($urandom_range(3))
      0: r.key = 16'($urandom_range(3));
      1: r.key = 16'hFFFF - 16'($urandom_range(3));
      default: r.key = 16'($urandom);
    endcase
    r.handle = 4'($urandom_range(NSLOTS - 1));
    if ($urandom_range(9) != 0) begin
      start = $urandom_range(NSLOTS - 1);
      for (k = NSLOTS - 1; k >= 0; k--) begin
        if (pq_valid[(start + k) % NSLOTS]) r.handle = 4'((start + k) % NSLOTS);
      end
    end
    if ($urandom_range(99) < insert_pct) begin
      r.command = CMD_INSERT;
    end else begin
      case ($urandom_range(3))
        0, 1: r.command = CMD_DEL_MAX;
        2: r.command = CMD_CHANGE;
        default: r.command = CMD_DELETE;
      endcase
    end
    return r;
  endfunction

  task automatic send_request(input in_req_t req, input logic typed, input out_res_t typed_res);
    out_res_t res;
    @(negedge clk);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    res = pq_predict(req);
    status_hits[res.status]++;
    requests_sent++;
    expected_q.push_back(typed ? typed_res : res);
  endtask

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < rx_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        $display({"%0t: unexpected result, expected none, ",
                  "got status=%0d key=%h handle=%0d empty=%0d count=%0d"},
                 $time, out_data.status, out_data.out_key, out_data.out_handle,
                 out_data.is_empty, out_data.entry_count);
        errors++;
      end else begin
        want = expected_q.pop_front();
        results_checked++;
        if (out_data.status !== want.status || out_data.out_key !== want.out_key ||
            out_data.out_handle !== want.out_handle || out_data.is_empty !== want.is_empty ||
            out_data.entry_count !== want.entry_count) begin
          $display("%0t: mismatch, expected status=%0d key=%h handle=%0d empty=%0d count=%0d",
                   $time, want.status, want.out_key, want.out_handle, want.is_empty,
                   want.entry_count);
          $display("%0t:           got status=%0d key=%h handle=%0d empty=%0d count=%0d",
                   $time, out_data.status, out_data.out_key, out_data.out_handle,
                   out_data.is_empty, out_data.entry_count);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("%0t: timeout with %0d results outstanding", $time, expected_q.size());
      $display("tb_top: done, errors");
      $finish;
    end
  end

  initial begin
    int n;
    int insert_pct;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    errors = 0;
    results_checked = 0;
    requests_sent = 0;
    cycles = 0;
    status_hits = '{0, 0, 0, 0};
    tx_idle_pct = 24;
    rx_idle_pct = 70;
    insert_pct = 50;
    for (n = 0; n < NSLOTS; n++) begin
      pq_valid[n] = 1'b0;
      pq_key[n] = '0;
      pq_rank[n] = 0;
    end
    pq_count = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (n = 0; n < DIR_ROWS_N; n++) begin
      send_request(DIR_ROWS[n].req, DIR_ROWS[n].typed, DIR_ROWS[n].res);
    end

    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 3) begin
        tx_idle_pct = 70;
        rx_idle_pct = 24;
      end
      if (n == 2 * RANDOM_ITEMS / 3) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      // Swing between filling and draining so both the full and empty ends get hit.
      if (n % 40 == 0) begin
        case ($urandom_range(2))
          0: insert_pct = 15;
          1: insert_pct = 45;
          default: insert_pct = 75;
        endcase
      end
      send_request(random_request(insert_pct), 1'b0, NO_RES);
    end
    @(negedge clk);
    in_valid <= 1'b0;

    while (expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("tb_top: %0d requests (%0d directed), %0d results checked",
             requests_sent, DIR_ROWS_N, results_checked);
    $display("tb_top: refusals seen: %0d empty, %0d full, %0d bad handle",
             status_hits[ST_EMPTY], status_hits[ST_FULL], status_hits[ST_BAD_HANDLE]);
    if (errors == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/mpq_pkg.sv
rtl/mpq_ram.sv
rtl/mpq_scan_unit.sv
rtl/max_priority_queue_with_handles_core.sv
verif/tb_top.sv
